// ===== src/fhss_hop_link_controller_unit_defines.svh =====
`ifndef FHSS_HOP_LINK_CONTROLLER_UNIT_DEFINES_SVH
`define FHSS_HOP_LINK_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FHSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FHSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fhss_pkg.sv =====
package fhss_pkg;

    localparam int MAX_HOPS            = 16;
    localparam int TABLE_ENTRIES       = 16;
    localparam int TIMEOUT_EXTRA_SLOTS = 5;

    localparam int IDX_W      = 4;
    localparam int LEN_W      = 5;
    localparam int PERIOD_W   = 16;
    localparam int TIME_W     = 32;
    localparam int CHAN_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;

    localparam int LEN_CAP = (MAX_HOPS < TABLE_ENTRIES) ? MAX_HOPS : TABLE_ENTRIES;

    typedef enum logic [2:0] {
        CFG_ROLE       = 3'd0,
        CFG_DUPLEX     = 3'd1,
        CFG_HOP_LENGTH = 3'd2,
        CFG_HOP_PERIOD = 3'd3,
        CFG_TABLE_LOW  = 3'd4,
        CFG_TABLE_HIGH = 3'd5
    } cfg_reg_t;

    // v mod len for v <= 16, len in 1..16, restoring compare/subtract
    function automatic logic [IDX_W-1:0] hop_mod(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] len);
        logic [2*LEN_W-1:0] rem;
        logic [2*LEN_W-1:0] div;
        rem = {{LEN_W{1'b0}}, v};
        for (int k = LEN_W - 1; k >= 0; k--) begin
            div = {{LEN_W{1'b0}}, len} << k;
            if (rem >= div) begin
                rem = rem - div;
            end
        end
        return rem[IDX_W-1:0];
    endfunction

endpackage

// ===== src/fhss_hop_link_controller_unit.sv =====
// The result passes through the input register, then the result register.
// Throughput: one item per cycle while m_tready is high; the result register
//   frees as it is taken.
// Reset (aresetn low, synchronous): hop index, lock, last rx time, radio mode
//   and success count clear; config returns to transmitter, simplex,
//   length 1, period 10 ms, empty hop table.
`include "fhss_hop_link_controller_unit_defines.svh"

module fhss_hop_link_controller_unit #(
    parameter int MaxHops = fhss_pkg::MAX_HOPS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB config
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fhss_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fhss_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fhss_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // input: now_ms[31:0], packet_received[32], send_done[33], zero pad
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fhss_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result: channel[7:0], hopped[8], do_transmit[9], radio_tx[10],
    //   locked[11], sent_count[27:12], zero pad
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fhss_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam logic [fhss_pkg::LEN_W-1:0] LenCap = fhss_pkg::LEN_W'(
        (MaxHops < fhss_pkg::TABLE_ENTRIES) ? MaxHops : fhss_pkg::TABLE_ENTRIES);
    localparam logic [fhss_pkg::LEN_W-1:0] Extra  =
        fhss_pkg::LEN_W'(fhss_pkg::TIMEOUT_EXTRA_SLOTS);
    localparam logic [fhss_pkg::COUNT_W-1:0] CountMax = '1;

    // config registers
    logic                              role_rx_reg;
    logic                              duplex_reg;
    logic [fhss_pkg::LEN_W-1:0]        hop_length_reg;
    logic [fhss_pkg::PERIOD_W-1:0]     hop_period_reg;
    logic [63:0]                       table_low_reg;
    logic [63:0]                       table_high_reg;

    // link state
    logic [fhss_pkg::IDX_W-1:0]        hop_index_reg,   hop_index_next;
    logic                              locked_reg,      locked_next;
    logic [fhss_pkg::TIME_W-1:0]       last_rx_reg,     last_rx_next;
    logic                              radio_tx_reg,    radio_tx_next;
    logic [fhss_pkg::COUNT_W-1:0]      count_reg,       count_next;

    // input and result stages
    logic                              in_valid_reg;
    logic [fhss_pkg::TIME_W-1:0]       in_now_reg;
    logic                              in_pkt_reg;
    logic                              in_sdone_reg;
    logic                              out_valid_reg;
    logic [fhss_pkg::OUT_TDATA_W-1:0]  out_data_reg,    out_data_next;

    logic                              cfg_wr;
    fhss_pkg::cfg_reg_t                cfg_sel;
    logic                              advance;

    logic [fhss_pkg::LEN_W-1:0]        eff_len;
    logic [fhss_pkg::IDX_W-1:0]        idx_once;
    logic [fhss_pkg::IDX_W-1:0]        idx_twice;
    logic [fhss_pkg::LEN_W-1:0]        idx_once_inc;
    logic [20:0]                       limit;
    logic [fhss_pkg::TIME_W-1:0]       last_eff;
    logic [fhss_pkg::TIME_W-1:0]       elapsed;
    logic                              timed_out;
    logic                              hopped;
    logic                              xmit;
    logic [fhss_pkg::COUNT_W-1:0]      count_inc;
    logic [3:0]                        tbl_sel;
    logic [63:0]                       tbl_word;
    logic [fhss_pkg::CHAN_W-1:0]       channel;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = fhss_pkg::cfg_reg_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_rx_reg    <= 1'b0;
            duplex_reg     <= 1'b0;
            hop_length_reg <= fhss_pkg::LEN_W'(1);
            hop_period_reg <= fhss_pkg::PERIOD_W'(10);
            table_low_reg  <= '0;
            table_high_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                fhss_pkg::CFG_ROLE:       role_rx_reg    <= pwdata[0];
                fhss_pkg::CFG_DUPLEX:     duplex_reg     <= pwdata[0];
                fhss_pkg::CFG_HOP_LENGTH: hop_length_reg <= pwdata[fhss_pkg::LEN_W-1:0];
                fhss_pkg::CFG_HOP_PERIOD: hop_period_reg <= pwdata[fhss_pkg::PERIOD_W-1:0];
                fhss_pkg::CFG_TABLE_LOW:  table_low_reg  <= pwdata;
                fhss_pkg::CFG_TABLE_HIGH: table_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            fhss_pkg::CFG_ROLE:       prdata = {63'd0, role_rx_reg};
            fhss_pkg::CFG_DUPLEX:     prdata = {63'd0, duplex_reg};
            fhss_pkg::CFG_HOP_LENGTH: prdata = {59'd0, hop_length_reg};
            fhss_pkg::CFG_HOP_PERIOD: prdata = {48'd0, hop_period_reg};
            fhss_pkg::CFG_TABLE_LOW:  prdata = table_low_reg;
            fhss_pkg::CFG_TABLE_HIGH: prdata = table_high_reg;
            default:                  prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg   <= s_tdata[31:0];
            in_pkt_reg   <= s_tdata[32];
            in_sdone_reg <= s_tdata[33];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------- hop arithmetic ----------------
    always_comb begin
        if (hop_length_reg == '0) begin
            eff_len = fhss_pkg::LEN_W'(1);
        end else if (hop_length_reg > LenCap) begin
            eff_len = LenCap;
        end else begin
            eff_len = hop_length_reg;
        end
    end

    assign idx_once     = fhss_pkg::hop_mod({1'b0, hop_index_reg} + fhss_pkg::LEN_W'(1),
                                            eff_len);
    assign idx_once_inc = {1'b0, idx_once} + fhss_pkg::LEN_W'(1);
    assign idx_twice    = (idx_once_inc == eff_len) ? '0 : idx_once_inc[fhss_pkg::IDX_W-1:0];

    assign limit     = 21'(hop_period_reg) * 21'(eff_len + Extra);
    assign last_eff  = in_pkt_reg ? in_now_reg : last_rx_reg;
    assign elapsed   = in_now_reg - last_eff;
    assign timed_out = elapsed >= {11'd0, limit};
    assign count_inc = (count_reg != CountMax) ? count_reg + fhss_pkg::COUNT_W'(1) : count_reg;

    // ---------------- per-call decision ----------------
    always_comb begin
        hop_index_next = hop_index_reg;
        locked_next    = locked_reg;
        last_rx_next   = last_rx_reg;
        radio_tx_next  = radio_tx_reg;
        count_next     = count_reg;
        hopped         = 1'b0;
        xmit           = 1'b0;
        if (!role_rx_reg) begin
            if (!duplex_reg) begin
                hop_index_next = idx_once;
                hopped         = 1'b1;
                xmit           = 1'b1;
            end else if (!radio_tx_reg) begin
                hop_index_next = idx_once;
                hopped         = 1'b1;
                radio_tx_next  = 1'b1;
                xmit           = 1'b1;
            end else if (in_sdone_reg) begin
                count_next    = count_inc;
                radio_tx_next = 1'b0;
            end else begin
                xmit = 1'b1;
            end
        end else if (!duplex_reg) begin
            // locked hop, then timeout hop: up to two steps
            hopped = locked_reg | in_pkt_reg | timed_out;
            if ((locked_reg | in_pkt_reg) && timed_out) begin
                hop_index_next = idx_twice;
            end else if (hopped) begin
                hop_index_next = idx_once;
            end
            if (timed_out) begin
                last_rx_next = in_now_reg;
                locked_next  = 1'b0;
            end else if (in_pkt_reg) begin
                last_rx_next = in_now_reg;
                locked_next  = 1'b1;
            end
        end else if (radio_tx_reg) begin
            if (in_sdone_reg) begin
                count_next = count_inc;
            end
            if (locked_reg) begin
                hop_index_next = idx_once;
                hopped         = 1'b1;
            end
            radio_tx_next = 1'b0;
        end else if (in_pkt_reg) begin
            last_rx_next  = in_now_reg;
            locked_next   = 1'b1;
            radio_tx_next = 1'b1;
            xmit          = 1'b1;
        end else if (timed_out) begin
            last_rx_next   = in_now_reg;
            hop_index_next = idx_once;
            hopped         = 1'b1;
            locked_next    = 1'b0;
        end
    end

    assign tbl_sel  = hop_index_next;
    assign tbl_word = tbl_sel[3] ? table_high_reg : table_low_reg;
    assign channel  = tbl_word[{tbl_sel[2:0], 3'b000} +: fhss_pkg::CHAN_W];

    assign out_data_next = {4'd0, count_next, locked_next, radio_tx_next, xmit, hopped,
                            channel};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_index_reg <= '0;
            locked_reg    <= 1'b0;
            last_rx_reg   <= '0;
            radio_tx_reg  <= 1'b0;
            count_reg     <= '0;
        end else if (advance) begin
            hop_index_reg <= hop_index_next;
            locked_reg    <= locked_next;
            last_rx_reg   <= last_rx_next;
            radio_tx_reg  <= radio_tx_next;
            count_reg     <= count_next;
        end
    end

    // ---------------- checks ----------------
    `FHSS_ASSERT_NEXT(a_index_in_range, advance && hopped,
        hop_index_reg < $past(eff_len), "hop index beyond length after hop")
    `FHSS_ASSERT_NEXT(a_count_monotonic, advance, count_reg >= $past(count_reg),
        "success count decreased")
    `FHSS_ASSERT_IMP(a_duplex_xmit_tx, out_valid_reg && out_data_reg[9] && duplex_reg,
        out_data_reg[10], "duplex transmit request without transmit mode")

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        send_done;
        logic        packet_received;
        logic [31:0] now_ms;
    } hop_call_t;

    typedef struct packed {
        logic [15:0] sent_count;
        logic        locked;
        logic        radio_tx;
        logic        do_transmit;
        logic        hopped;
        logic [7:0]  channel;
    } hop_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [fhss_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [fhss_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [fhss_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // now_ms[31:0], packet_received[32], send_done[33], zero pad
    logic [fhss_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // channel[7:0], hopped[8], do_transmit[9], radio_tx[10], locked[11],
    // sent_count[27:12], zero pad
    logic [fhss_pkg::OUT_TDATA_W-1:0] m_tdata;

    fhss_hop_link_controller_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor copy of config and link state
    logic        cfg_receiver = 1'b0;
    logic        cfg_duplex = 1'b0;
    logic [4:0]  cfg_len = 5'd1;
    logic [15:0] cfg_period = 16'd10;
    logic [63:0] cfg_tab_lo = '0;
    logic [63:0] cfg_tab_hi = '0;

    int unsigned hop_idx = 0;
    logic        link_locked = 1'b0;
    logic [31:0] rx_stamp_ms = '0;
    logic        tx_mode = 1'b0;
    logic [15:0] ok_sends = '0;

    hop_call_t   call_q[$];
    hop_result_t hop_result_q[$];
    int          mismatch_count = 0;
    int unsigned send_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic [31:0] clock_ms = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned active_len();
        int unsigned n;
        n = cfg_len;
        if (n == 0) n = 1;
        if (n > fhss_pkg::LEN_CAP) n = fhss_pkg::LEN_CAP;
        return n;
    endfunction

    function automatic logic advance_hop();
        hop_idx = (hop_idx + 1) % active_len();
        return 1'b1;
    endfunction

    function automatic logic silence_expired(logic [31:0] now);
        logic [31:0] lim;
        logic [31:0] gap;
        lim = 32'(cfg_period) * 32'(active_len() + fhss_pkg::TIMEOUT_EXTRA_SLOTS);
        gap = now - rx_stamp_ms;
        return gap >= lim;
    endfunction

    function automatic void count_send();
        if (ok_sends != 16'hFFFF) ok_sends++;
    endfunction

    function automatic hop_result_t predict_hop_call(hop_call_t c);
        hop_result_t r;
        logic [3:0]  slot;
        logic [63:0] word;
        r = '0;
        if (!cfg_receiver) begin
            if (!cfg_duplex) begin
                r.hopped = advance_hop();
                r.do_transmit = 1'b1;
            end else if (!tx_mode) begin
                r.hopped = advance_hop();
                tx_mode = 1'b1;
                r.do_transmit = 1'b1;
            end else if (c.send_done) begin
                count_send();
                tx_mode = 1'b0;
            end else begin
                r.do_transmit = 1'b1;
            end
        end else if (!cfg_duplex) begin
            if (c.packet_received) begin
                rx_stamp_ms = c.now_ms;
                link_locked = 1'b1;
            end
            if (link_locked) r.hopped = advance_hop();
            if (silence_expired(c.now_ms)) begin
                rx_stamp_ms = c.now_ms;
                r.hopped = advance_hop();
                link_locked = 1'b0;
            end
        end else if (tx_mode) begin
            if (c.send_done) count_send();
            if (link_locked) r.hopped = advance_hop();
            tx_mode = 1'b0;
        end else if (c.packet_received) begin
            rx_stamp_ms = c.now_ms;
            link_locked = 1'b1;
            tx_mode = 1'b1;
            r.do_transmit = 1'b1;
        end else begin
            if (silence_expired(c.now_ms)) begin
                rx_stamp_ms = c.now_ms;
                r.hopped = advance_hop();
                link_locked = 1'b0;
            end
            tx_mode = 1'b0;
        end
        slot = hop_idx[3:0];
        word = slot[3] ? cfg_tab_hi : cfg_tab_lo;
        r.channel = word[8*slot[2:0] +: 8];
        r.radio_tx = tx_mode;
        r.locked = link_locked;
        r.sent_count = ok_sends;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // driver
    always @(posedge aclk) begin : call_feed
        logic took;
        took = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (took) begin
                hop_result_q.push_back(predict_hop_call(call_q[0]));
                void'(call_q.pop_front());
            end
            if (s_tvalid && !took) begin
                // hold the pending transfer
            end else if (call_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= fhss_pkg::IN_TDATA_W'(call_q[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : result_check
        hop_result_t want;
        hop_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                if (hop_result_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected result: expected none, actual %0h",
                             $time, got);
                end else begin
                    want = hop_result_q.pop_front();
                    check_field("channel", want.channel, got.channel);
                    check_field("hopped", want.hopped, got.hopped);
                    check_field("do_transmit", want.do_transmit, got.do_transmit);
                    check_field("radio_tx", want.radio_tx, got.radio_tx);
                    check_field("locked", want.locked, got.locked);
                    check_field("sent_count", want.sent_count, got.sent_count);
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic write_reg(fhss_pkg::cfg_reg_t r, logic [63:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 3'b000};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            fhss_pkg::CFG_ROLE:       cfg_receiver = v[0];
            fhss_pkg::CFG_DUPLEX:     cfg_duplex = v[0];
            fhss_pkg::CFG_HOP_LENGTH: cfg_len = v[4:0];
            fhss_pkg::CFG_HOP_PERIOD: cfg_period = v[15:0];
            fhss_pkg::CFG_TABLE_LOW:  cfg_tab_lo = v;
            fhss_pkg::CFG_TABLE_HIGH: cfg_tab_hi = v;
            default: ;
        endcase
    endtask

    task automatic push_call(logic [31:0] now, logic pkt, logic done);
        hop_call_t c;
        c.now_ms = now;
        c.packet_received = pkt;
        c.send_done = done;
        call_q.push_back(c);
    endtask

    task automatic wait_idle();
        while (call_q.size() != 0 || s_tvalid || hop_result_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic randomize_config();
        logic [63:0] tab;
        write_reg(fhss_pkg::CFG_ROLE, 64'($urandom_range(1)));
        write_reg(fhss_pkg::CFG_DUPLEX, 64'($urandom_range(1)));
        case ($urandom_range(9))
            0: write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd0);
            1: write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd1);
            2: write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd16);
            3: write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'($urandom_range(17, 31)));
            default: write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'($urandom_range(2, 15)));
        endcase
        case ($urandom_range(7))
            0: write_reg(fhss_pkg::CFG_HOP_PERIOD, 64'd0);
            1: write_reg(fhss_pkg::CFG_HOP_PERIOD, 64'hFFFF);
            default: write_reg(fhss_pkg::CFG_HOP_PERIOD, 64'($urandom_range(1, 50)));
        endcase
        // a repeated byte makes hops that keep the same channel
        tab = {8{8'($urandom)}};
        write_reg(fhss_pkg::CFG_TABLE_LOW,
                  ($urandom_range(3) == 0) ? tab : {$urandom, $urandom});
        write_reg(fhss_pkg::CFG_TABLE_HIGH,
                  ($urandom_range(3) == 0) ? tab : {$urandom, $urandom});
    endtask

    task automatic run_random(int n);
        int unsigned step_max;
        step_max = (cfg_period == 0) ? 20 : 2 * cfg_period;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(0, step_max);
            push_call(clock_ms, $urandom_range(9) < 3, $urandom_range(9) < 6);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset config: transmitter, simplex, single slot
        push_call(32'h0, 1'b0, 1'b0);
        push_call(32'hFFFF_FFFF, 1'b1, 1'b1);
        wait_idle();

        // transmitter duplex over a full table; slots 0 and 1 share a channel
        write_reg(fhss_pkg::CFG_TABLE_LOW, 64'hFF80_7F01_55AA_0000);
        write_reg(fhss_pkg::CFG_TABLE_HIGH, 64'h00FF_0102_0408_1020);
        write_reg(fhss_pkg::CFG_DUPLEX, 64'd1);
        write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd16);
        @(negedge aclk);
        push_call(32'd5, 1'b0, 1'b0);
        push_call(32'd6, 1'b0, 1'b0);
        push_call(32'd7, 1'b0, 1'b1);
        push_call(32'd8, 1'b1, 1'b1);
        wait_idle();

        // receiver simplex: lock, double hop on timeout, time wrap
        write_reg(fhss_pkg::CFG_ROLE, 64'd1);
        write_reg(fhss_pkg::CFG_DUPLEX, 64'd0);
        write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd3);
        @(negedge aclk);
        push_call(32'd10, 1'b0, 1'b0);
        push_call(32'd20, 1'b1, 1'b0);
        push_call(32'd30, 1'b0, 1'b0);
        push_call(32'd200, 1'b0, 1'b0);
        push_call(32'hFFFF_FFF0, 1'b1, 1'b0);
        push_call(32'h10, 1'b0, 1'b0);
        push_call(32'h60, 1'b0, 1'b0);
        wait_idle();

        // receiver duplex
        write_reg(fhss_pkg::CFG_DUPLEX, 64'd1);
        @(negedge aclk);
        push_call(32'h70, 1'b0, 1'b0);
        push_call(32'h80, 1'b1, 1'b0);
        push_call(32'h85, 1'b0, 1'b1);
        push_call(32'h90, 1'b0, 1'b0);
        push_call(32'h400, 1'b0, 1'b0);
        wait_idle();

        // zero length and zero period
        write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd0);
        write_reg(fhss_pkg::CFG_HOP_PERIOD, 64'd0);
        write_reg(fhss_pkg::CFG_DUPLEX, 64'd0);
        @(negedge aclk);
        push_call(32'd1, 1'b0, 1'b0);
        push_call(32'd2, 1'b1, 1'b1);
        wait_idle();

        // oversized length clamps, then shrink below the index
        write_reg(fhss_pkg::CFG_ROLE, 64'd0);
        write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd31);
        write_reg(fhss_pkg::CFG_HOP_PERIOD, 64'd10);
        @(negedge aclk);
        push_call(32'd3, 1'b0, 1'b0);
        push_call(32'd4, 1'b0, 1'b0);
        push_call(32'd5, 1'b0, 1'b0);
        wait_idle();
        write_reg(fhss_pkg::CFG_HOP_LENGTH, 64'd2);
        @(negedge aclk);
        push_call(32'd6, 1'b0, 1'b0);
        wait_idle();

        for (int p = 0; p < 16; p++) begin
            randomize_config();
            case (p % 4)
                0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_gap_pct = 52; sink_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  sink_stall_pct = 52; end
                default: begin send_gap_pct = 31; sink_stall_pct = 31; end
            endcase
            if (p % 5 == 2) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
            @(negedge aclk);
            run_random($urandom_range(60, 100));
            wait_idle();
        end

        randomize_config();
        send_gap_pct = 31;
        sink_stall_pct = 31;
        @(negedge aclk);
        run_random(40);
        wait_idle();
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && hop_result_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
